FILE: src/timer_wheel_scheduler_assert.svh
// Assertion macros for the timer wheel scheduler.
// Used by the datapath; expects signals named clk and rst_n in scope.
`ifndef TIMER_WHEEL_SCHEDULER_ASSERT_SVH
`define TIMER_WHEEL_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
`define TWS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TWS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TWS_ASSERT(lbl, cond, msg)
`define TWS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: src/tws_pkg.sv
// Shared constants and types of the timer wheel scheduler.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package tws_pkg;
  localparam int WHEEL_SLOTS = 256;
  localparam int ENTRY_COUNT = 1024;

  localparam int SW  = $clog2(WHEEL_SLOTS);       // slot index width
  localparam int EW  = $clog2(ENTRY_COUNT);       // entry index width
  localparam int LW  = EW + 1;                    // link width, top bit marks empty
  localparam int PLW = $clog2(WHEEL_SLOTS + 3);   // place code width
  localparam int CLR_N = (ENTRY_COUNT > WHEEL_SLOTS) ? ENTRY_COUNT : WHEEL_SLOTS;
  localparam int CW  = $clog2(CLR_N + 1);

  localparam logic [LW-1:0]  NIL      = {1'b1, {EW{1'b0}}};
  localparam logic [PLW-1:0] PL_OVF   = PLW'(WHEEL_SLOTS);
  localparam logic [PLW-1:0] PL_EXP   = PLW'(WHEEL_SLOTS + 1);
  localparam logic [PLW-1:0] PL_NONE  = PLW'(WHEEL_SLOTS + 2);

  localparam logic [1:0] OP_SCHED  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  typedef enum logic [3:0] {
    ST_NOP, ST_CLEAR, ST_ACCEPT, ST_U_RD, ST_U_WR, ST_L_RD, ST_L_WR, ST_L_FIX,
    ST_T_ADV, ST_T_HRD, ST_T_HCAP, ST_W_RD, ST_W_CAP, ST_OVF_START, ST_RESP
  } step_t;

  typedef struct packed {
    step_t step;
    logic  walk;
    logic  ovf_mode;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic exp_nil;
    logic i_nil;
    logic pos_zero;
    logic in_range;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

FILE: src/tws_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/tws_ctrl.sv
// Controller state machine of the timer wheel scheduler.
// Depends on tws_pkg; drives the datapath through cmd_t, reads sts_t.
`default_nettype none
module tws_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_op,
  input  tws_pkg::sts_t     sts,
  output tws_pkg::cmd_t     cmd
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_URD, S_UWR, S_LRD, S_LWR, S_LFIX,
    S_TADV, S_THRD, S_THCAP, S_WRD, S_WCAP, S_RESP
  } state_t;

  state_t     state_r;
  logic [1:0] op_r;
  logic       walk_r;
  logic       ovf_mode_r;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // step issued to the datapath in each state
  always_comb begin
    cmd.walk     = walk_r;
    cmd.ovf_mode = ovf_mode_r;
    case (state_r)
      S_CLEAR: cmd.step = tws_pkg::ST_CLEAR;
      S_IDLE:  cmd.step = accept ? tws_pkg::ST_ACCEPT : tws_pkg::ST_NOP;
      S_URD:   cmd.step = tws_pkg::ST_U_RD;
      S_UWR:   cmd.step = tws_pkg::ST_U_WR;
      S_LRD:   cmd.step = tws_pkg::ST_L_RD;
      S_LWR:   cmd.step = tws_pkg::ST_L_WR;
      S_LFIX:  cmd.step = tws_pkg::ST_L_FIX;
      S_TADV:  cmd.step = tws_pkg::ST_T_ADV;
      S_THRD:  cmd.step = tws_pkg::ST_T_HRD;
      S_THCAP: cmd.step = tws_pkg::ST_T_HCAP;
      S_WRD: begin
        if (!sts.i_nil) begin
          cmd.step = tws_pkg::ST_W_RD;
        end else if (!ovf_mode_r && sts.pos_zero) begin
          cmd.step = tws_pkg::ST_OVF_START;
        end else begin
          cmd.step = tws_pkg::ST_NOP;
        end
      end
      S_WCAP:  cmd.step = tws_pkg::ST_W_CAP;
      S_RESP:  cmd.step = sts.out_free ? tws_pkg::ST_RESP : tws_pkg::ST_NOP;
      default: cmd.step = tws_pkg::ST_NOP;
    endcase
  end

  // state and registered flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      op_r       <= tws_pkg::OP_SCHED;
      walk_r     <= 1'b0;
      ovf_mode_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (sts.clr_done) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op_r       <= in_op;
            walk_r     <= 1'b0;
            ovf_mode_r <= 1'b0;
            case (in_op)
              tws_pkg::OP_SCHED, tws_pkg::OP_CANCEL:
                state_r <= sts.in_range ? S_URD : S_RESP;
              tws_pkg::OP_TICK: state_r <= S_TADV;
              default:          state_r <= sts.exp_nil ? S_RESP : S_URD;
            endcase
          end
        end
        S_URD: state_r <= S_UWR;
        S_UWR: state_r <= (op_r == tws_pkg::OP_SCHED) ? S_LRD : S_RESP;
        S_LRD: state_r <= S_LWR;
        S_LWR: state_r <= S_LFIX;
        S_LFIX: state_r <= walk_r ? S_WRD : S_RESP;
        S_TADV: state_r <= S_THRD;
        S_THRD: state_r <= S_THCAP;
        S_THCAP: begin
          walk_r  <= 1'b1;
          state_r <= S_WRD;
        end
        S_WRD: begin
          if (!sts.i_nil) begin
            state_r <= S_WCAP;
          end else if (!ovf_mode_r && sts.pos_zero) begin
            ovf_mode_r <= 1'b1;
          end else begin
            state_r <= S_RESP;
          end
        end
        S_WCAP: state_r <= S_LRD;
        S_RESP: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/tws_dp.sv
// Datapath of the timer wheel scheduler: link memories, heads, wheel
// position, tick count and result register. Depends on tws_pkg, tws_ram.
`default_nettype none
`include "timer_wheel_scheduler_assert.svh"
module tws_dp (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  tws_pkg::cmd_t     cmd,
  output tws_pkg::sts_t     sts,
  input  wire logic [1:0]   in_op,
  input  wire logic [9:0]   in_entry,
  input  wire logic [23:0]  in_delay,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata
);
  localparam int EW  = tws_pkg::EW;
  localparam int LW  = tws_pkg::LW;
  localparam int SW  = tws_pkg::SW;
  localparam int PLW = tws_pkg::PLW;
  localparam int CW  = tws_pkg::CW;

  // control registers
  logic [LW-1:0]  exp_r, ovf_r;
  logic [SW-1:0]  pos_r;
  logic [31:0]    tick_r;
  logic [CW-1:0]  clr_cnt_r;
  logic           out_valid_r;
  // payload registers
  logic [1:0]     op_r;
  logic [EW-1:0]  e_r;
  logic [23:0]    d_r;
  logic [LW-1:0]  i_r, nx_r, old_r;
  logic [PLW-1:0] tgt_r;
  logic           ev_r, ws_r, ov_r;
  logic [23:0]    out_r;

  // memory ports
  logic           nx_we, pv_we, pl_we, dl_we, sl_we;
  logic [EW-1:0]  nx_wa, pv_wa, pl_wa, dl_wa, nx_ra;
  logic [SW-1:0]  sl_wa, sl_ra;
  logic [LW-1:0]  nx_wd, pv_wd, sl_wd, nx_rd, pv_rd, sl_rd;
  logic [PLW-1:0] pl_wd, pl_rd;
  logic [31:0]    dl_wd, dl_rd;

  tws_ram #(.WIDTH(LW), .DEPTH(tws_pkg::ENTRY_COUNT)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  tws_ram #(.WIDTH(LW), .DEPTH(tws_pkg::ENTRY_COUNT)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(e_r), .rdata(pv_rd));
  tws_ram #(.WIDTH(PLW), .DEPTH(tws_pkg::ENTRY_COUNT)) u_place (
    .clk(clk), .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(e_r), .rdata(pl_rd));
  tws_ram #(.WIDTH(32), .DEPTH(tws_pkg::ENTRY_COUNT)) u_deadline (
    .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(i_r[EW-1:0]),
    .rdata(dl_rd));
  tws_ram #(.WIDTH(LW), .DEPTH(tws_pkg::WHEEL_SLOTS)) u_slot (
    .clk(clk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd));

  // unlink decode (place, next, prev of e_r are on the read ports)
  logic linked, pl_is_slot, pv_nil, nxt_nil;
  assign linked     = (pl_rd <= tws_pkg::PL_EXP);
  assign pl_is_slot = (pl_rd < tws_pkg::PL_OVF);
  assign pv_nil     = pv_rd[EW];
  assign nxt_nil    = nx_rd[EW];

  // schedule target: delay of zero counts as one tick
  logic [23:0]   d1;
  logic          sched_ovf;
  logic [SW:0]   sum;
  logic [SW-1:0] sched_slot;
  logic [31:0]   rem;
  assign d1         = (d_r == 24'd0) ? 24'd1 : d_r;
  assign sched_ovf  = (32'(d1) >= 32'(tws_pkg::WHEEL_SLOTS));
  assign sum        = (SW+1)'(pos_r) + (SW+1)'(d1);
  assign sched_slot = (sum >= (SW+1)'(tws_pkg::WHEEL_SLOTS))
                      ? SW'(sum - (SW+1)'(tws_pkg::WHEEL_SLOTS)) : SW'(sum);
  assign rem        = dl_rd - tick_r;

  // old head of the link target
  logic          tgt_is_slot;
  logic [LW-1:0] old_l;
  assign tgt_is_slot = (tgt_r < tws_pkg::PL_OVF);
  assign old_l = tgt_is_slot ? sl_rd : ((tgt_r == tws_pkg::PL_OVF) ? ovf_r : exp_r);

  // memory read address selection
  assign nx_ra = (cmd.step == tws_pkg::ST_W_RD) ? i_r[EW-1:0] : e_r;
  assign sl_ra = (cmd.step == tws_pkg::ST_T_HRD) ? pos_r : tgt_r[SW-1:0];

  // memory writes per step
  always_comb begin
    nx_we = 1'b0; nx_wa = e_r; nx_wd = tws_pkg::NIL;
    pv_we = 1'b0; pv_wa = e_r; pv_wd = tws_pkg::NIL;
    pl_we = 1'b0; pl_wa = e_r; pl_wd = tws_pkg::PL_NONE;
    dl_we = 1'b0; dl_wa = e_r; dl_wd = tick_r + 32'(d1);
    sl_we = 1'b0; sl_wa = tgt_r[SW-1:0]; sl_wd = tws_pkg::NIL;
    case (cmd.step)
      tws_pkg::ST_CLEAR: begin
        pl_we = (32'(clr_cnt_r) < 32'(tws_pkg::ENTRY_COUNT));
        pl_wa = EW'(clr_cnt_r);
        sl_we = (32'(clr_cnt_r) < 32'(tws_pkg::WHEEL_SLOTS));
        sl_wa = SW'(clr_cnt_r);
      end
      tws_pkg::ST_U_WR: begin
        nx_we = linked && !pv_nil;
        nx_wa = pv_rd[EW-1:0];
        nx_wd = nx_rd;
        pv_we = linked && !nxt_nil;
        pv_wa = nx_rd[EW-1:0];
        pv_wd = pv_rd;
        pl_we = 1'b1;
        sl_we = linked && pv_nil && pl_is_slot;
        sl_wa = pl_rd[SW-1:0];
        sl_wd = nx_rd;
        dl_we = (op_r == tws_pkg::OP_SCHED);
      end
      tws_pkg::ST_L_WR: begin
        nx_we = 1'b1;
        nx_wd = old_l;
        pv_we = 1'b1;
        pl_we = 1'b1;
        pl_wd = tgt_r;
        sl_we = tgt_is_slot;
        sl_wd = {1'b0, e_r};
      end
      tws_pkg::ST_L_FIX: begin
        pv_we = !old_r[EW];
        pv_wa = old_r[EW-1:0];
        pv_wd = {1'b0, e_r};
      end
      tws_pkg::ST_T_HCAP: begin
        sl_we = 1'b1;
        sl_wa = pos_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= tws_pkg::NIL;
      ovf_r       <= tws_pkg::NIL;
      pos_r       <= '0;
      tick_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result register: loaded on a response step, freed when taken
      if (cmd.step == tws_pkg::ST_RESP) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.step)
        tws_pkg::ST_CLEAR: begin
          if (32'(clr_cnt_r) < 32'(tws_pkg::CLR_N)) clr_cnt_r <= clr_cnt_r + CW'(1);
        end
        tws_pkg::ST_U_WR: begin
          if (linked && pv_nil && (pl_rd == tws_pkg::PL_OVF)) ovf_r <= nx_rd;
          if (linked && pv_nil && (pl_rd == tws_pkg::PL_EXP)) exp_r <= nx_rd;
        end
        tws_pkg::ST_L_WR: begin
          if (tgt_r == tws_pkg::PL_OVF) ovf_r <= {1'b0, e_r};
          if (tgt_r == tws_pkg::PL_EXP) exp_r <= {1'b0, e_r};
        end
        tws_pkg::ST_T_ADV: begin
          pos_r  <= (pos_r == SW'(tws_pkg::WHEEL_SLOTS - 1)) ? '0 : pos_r + SW'(1);
          tick_r <= tick_r + 32'd1;
        end
        tws_pkg::ST_OVF_START: ovf_r <= tws_pkg::NIL;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.step)
      tws_pkg::ST_ACCEPT: begin
        op_r <= in_op;
        d_r  <= in_delay;
        ws_r <= 1'b0;
        ov_r <= 1'b0;
        if (in_op == tws_pkg::OP_POP) begin
          e_r  <= exp_r[EW-1:0];
          ev_r <= !exp_r[EW];
        end else begin
          e_r  <= EW'(in_entry);
          ev_r <= 1'b0;
        end
      end
      tws_pkg::ST_U_WR: begin
        if (op_r != tws_pkg::OP_POP) ws_r <= linked;
        if (sched_ovf) begin
          tgt_r <= tws_pkg::PL_OVF;
          ov_r  <= (op_r == tws_pkg::OP_SCHED);
        end else begin
          tgt_r <= PLW'(sched_slot);
        end
      end
      tws_pkg::ST_L_WR: old_r <= old_l;
      tws_pkg::ST_L_FIX: begin
        if (cmd.walk) i_r <= nx_r;
      end
      tws_pkg::ST_T_HCAP: i_r <= sl_rd;
      tws_pkg::ST_OVF_START: i_r <= ovf_r;
      tws_pkg::ST_W_CAP: begin
        nx_r <= nx_rd;
        e_r  <= i_r[EW-1:0];
        if (!cmd.ovf_mode || (rem == 32'd0)) begin
          tgt_r <= tws_pkg::PL_EXP;
        end else if (rem >= 32'(tws_pkg::WHEEL_SLOTS)) begin
          tgt_r <= tws_pkg::PL_OVF;
        end else begin
          tgt_r <= PLW'(rem[SW-1:0]);
        end
      end
      tws_pkg::ST_RESP: begin
        // fields from bit 0: valid, entry, more, was_scheduled, to_overflow, slot
        out_r <= {2'b00, 8'(pos_r), ov_r, ws_r, !exp_r[EW],
                  ev_r ? 10'(e_r) : 10'd0, ev_r};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  assign sts.clr_done = (32'(clr_cnt_r) == 32'(tws_pkg::CLR_N));
  assign sts.exp_nil  = exp_r[EW];
  assign sts.i_nil    = i_r[EW];
  assign sts.pos_zero = (pos_r == '0);
  assign sts.in_range = (32'(in_entry) < 32'(tws_pkg::ENTRY_COUNT));
  assign sts.out_free = !out_valid_r || out_tready;

  `TWS_ASSERT(a_exp_head_in_range, exp_r[EW] || (32'(exp_r[EW-1:0]) < 32'(tws_pkg::ENTRY_COUNT)), "expired head out of range")
  `TWS_ASSERT(a_resp_when_free, (cmd.step != tws_pkg::ST_RESP) || !out_valid_r || out_tready, "result overwritten while stalled")
  `TWS_ASSERT_NEXT(a_tick_moves, cmd.step == tws_pkg::ST_T_ADV, pos_r != $past(pos_r), "tick did not advance wheel")
endmodule
`default_nettype wire

FILE: src/timer_wheel_scheduler.sv
// Timer wheel scheduler top level: controller plus datapath.
// Depends on tws_pkg, tws_ctrl, tws_dp (and tws_ram through tws_dp).
//
// Usage: one item on the in_ channel carries an operation (schedule, cancel,
// tick, pop), an entry index and a delay in ticks. Every item yields exactly
// one result item on the out_ channel with the popped entry, list status,
// link flags and the wheel position after the operation.
// Steps from accept to result: cancel and a pop of a listed entry do an
// unlink read and write; a pop on an empty expired list goes straight to
// the result; schedule adds a head read, link write and back-pointer
// fix-up after the unlink. A tick advances the wheel, reads the new slot
// head and moves each entry out of that slot, and on a wrap to slot 0 also
// walks the overflow list. The sequence is set by the single read port on
// each link memory; one item is worked on at a time.
// After reset a clearing pass empties the slot heads and entry places;
// in_tready stays low meanwhile.
// Results sit in an output register: a stalled receiver holds the result
// and the next item is still accepted, but its result waits until the
// register is taken.
`default_nettype none
module timer_wheel_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] operation, [11:2] entry, [35:12] delay_slots, [39:36] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] expired_valid, [10:1] expired_entry, [11] more_expired,
  // [12] was_scheduled, [13] to_overflow, [21:14] current_slot, [23:22] zero
  output logic [23:0]      out_tdata
);
  tws_pkg::cmd_t cmd;
  tws_pkg::sts_t sts;

  tws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_op(in_tdata[1:0]), .sts(sts), .cmd(cmd));

  tws_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_tdata[1:0]), .in_entry(in_tdata[11:2]), .in_delay(in_tdata[35:12]),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
endmodule
`default_nettype wire

FILE: dv/tws_checker.sv
// Scoreboard for the timer wheel scheduler: watches both streams, keeps its own
// copy of the wheel, slot chains and lists, and compares every result item.
// Depends on tws_pkg for widths, operation codes and place codes.
`default_nettype none
module tws_checker
  import tws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [39:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  output int               error_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // fields from the top bit down, matching the result item layout
  typedef struct packed {
    logic [SW-1:0] current_slot;
    logic          to_overflow;
    logic          was_scheduled;
    logic          more_expired;
    logic [EW-1:0] expired_entry;
    logic          expired_valid;
  } wheel_result_t;

  // Shadow state of the wheel
  logic [LW-1:0]  slot_head_q [WHEEL_SLOTS];
  logic [LW-1:0]  ovf_head_q;
  logic [LW-1:0]  exp_head_q;
  logic [LW-1:0]  next_q [ENTRY_COUNT];
  logic [LW-1:0]  prev_q [ENTRY_COUNT];
  logic [PLW-1:0] place_q [ENTRY_COUNT];
  logic [31:0]    deadline_q [ENTRY_COUNT];
  logic [SW-1:0]  position_q;
  logic [31:0]    ticks_q;

  wheel_result_t expected_results [$];

  function automatic logic [LW-1:0] head_at(logic [PLW-1:0] pl);
    if (pl == PL_OVF) return ovf_head_q;
    if (pl == PL_EXP) return exp_head_q;
    return slot_head_q[pl[SW-1:0]];
  endfunction

  function automatic void set_head(logic [PLW-1:0] pl, logic [LW-1:0] v);
    if (pl == PL_OVF) ovf_head_q = v;
    else if (pl == PL_EXP) exp_head_q = v;
    else slot_head_q[pl[SW-1:0]] = v;
  endfunction

  // Take an entry out of whatever list holds it; returns 1 if it was linked
  function automatic bit detach_entry(int e);
    logic [LW-1:0] nx, pv;
    if (place_q[e] == PL_NONE) return 1'b0;
    nx = next_q[e];
    pv = prev_q[e];
    if (pv == NIL) set_head(place_q[e], nx);
    else next_q[pv[EW-1:0]] = nx;
    if (nx != NIL) prev_q[nx[EW-1:0]] = pv;
    place_q[e] = PL_NONE;
    next_q[e]  = NIL;
    prev_q[e]  = NIL;
    return 1'b1;
  endfunction

  // Push an entry at the head of a list
  function automatic void attach_entry(int e, logic [PLW-1:0] pl);
    logic [LW-1:0] old;
    old = head_at(pl);
    prev_q[e] = NIL;
    next_q[e] = old;
    if (old != NIL) prev_q[old[EW-1:0]] = LW'(e);
    set_head(pl, LW'(e));
    place_q[e] = pl;
  endfunction

  function automatic void advance_wheel();
    logic [LW-1:0] i, nx;
    logic [31:0]   remain;
    position_q = position_q + 1'b1;
    ticks_q    = ticks_q + 1;
    i = slot_head_q[position_q];
    slot_head_q[position_q] = NIL;
    while (i != NIL) begin
      nx = next_q[i[EW-1:0]];
      attach_entry(i[EW-1:0], PL_EXP);
      i = nx;
    end
    // wrap: re-slot the far deadlines by their remaining time
    if (position_q == '0) begin
      i = ovf_head_q;
      ovf_head_q = NIL;
      while (i != NIL) begin
        remain = deadline_q[i[EW-1:0]] - ticks_q;
        nx = next_q[i[EW-1:0]];
        if (remain == 0) attach_entry(i[EW-1:0], PL_EXP);
        else if (remain >= WHEEL_SLOTS) attach_entry(i[EW-1:0], PL_OVF);
        else attach_entry(i[EW-1:0], PLW'(remain));
        i = nx;
      end
    end
  endfunction

  function automatic wheel_result_t apply_item(logic [39:0] item);
    wheel_result_t r;
    logic [1:0]    op;
    int            e;
    logic [31:0]   d;
    logic [LW-1:0] h;
    op = item[1:0];
    e  = item[11:2];
    d  = {8'd0, item[35:12]};
    r  = '0;
    case (op)
      OP_SCHED: begin
        r.was_scheduled = detach_entry(e);
        if (d == 0) d = 1;
        deadline_q[e] = ticks_q + d;
        if (d >= WHEEL_SLOTS) begin
          attach_entry(e, PL_OVF);
          r.to_overflow = 1'b1;
        end else begin
          attach_entry(e, PLW'(position_q + d[SW-1:0]));
        end
      end
      OP_CANCEL: r.was_scheduled = detach_entry(e);
      OP_TICK:   advance_wheel();
      default: begin
        h = exp_head_q;
        if (h != NIL) begin
          void'(detach_entry(h[EW-1:0]));
          r.expired_valid = 1'b1;
          r.expired_entry = h[EW-1:0];
        end
      end
    endcase
    r.more_expired = (exp_head_q != NIL);
    r.current_slot = position_q;
    return r;
  endfunction

  // Predict on each accepted input item, compare on each accepted result item
  always @(posedge clk) begin
    wheel_result_t got, exp_r;
    if (!rst_n) begin
      for (int i = 0; i < WHEEL_SLOTS; i++) slot_head_q[i] = NIL;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        next_q[i]     = NIL;
        prev_q[i]     = NIL;
        place_q[i]    = PL_NONE;
        deadline_q[i] = '0;
      end
      ovf_head_q  = NIL;
      exp_head_q  = NIL;
      position_q  = '0;
      ticks_q     = '0;
      error_count = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(apply_item(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[21:0];
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: %h", out_tdata);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.expired_valid !== exp_r.expired_valid) begin
            $error("expired_valid: expected %0d, got %0d", exp_r.expired_valid,
                   got.expired_valid);
            error_count++;
          end
          if (got.expired_entry !== exp_r.expired_entry) begin
            $error("expired_entry: expected %0d, got %0d", exp_r.expired_entry,
                   got.expired_entry);
            error_count++;
          end
          if (got.more_expired !== exp_r.more_expired) begin
            $error("more_expired: expected %0d, got %0d", exp_r.more_expired,
                   got.more_expired);
            error_count++;
          end
          if (got.was_scheduled !== exp_r.was_scheduled) begin
            $error("was_scheduled: expected %0d, got %0d", exp_r.was_scheduled,
                   got.was_scheduled);
            error_count++;
          end
          if (got.to_overflow !== exp_r.to_overflow) begin
            $error("to_overflow: expected %0d, got %0d", exp_r.to_overflow,
                   got.to_overflow);
            error_count++;
          end
          if (got.current_slot !== exp_r.current_slot) begin
            $error("current_slot: expected %0d, got %0d", exp_r.current_slot,
                   got.current_slot);
            error_count++;
          end
        end
      end
    end
    pending_count = expected_results.size();
  end
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// Top of the timer wheel scheduler testbench: clock, reset, stimulus and verdict.
// Depends on tws_pkg, timer_wheel_scheduler and tws_checker.
`default_nettype none
module testbench;
  import tws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  int          error_count;
  int          pending_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          items_sent;
  int          cycle_count;

  timer_wheel_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  tws_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop on a hang
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off early in the random part
  initial begin
    int hold_left;
    bit held;
    hold_left  = 0;
    held       = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_sent == 60) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item from the falling edge and hold it until accepted;
  // ready is read at the falling edge, where it is stable for the next rise
  task automatic send_item(logic [1:0] op, logic [EW-1:0] e, logic [23:0] d);
    bit ready_q;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, d, e, op};
    forever begin
      ready_q = in_tready;
      @(posedge clk);
      if (ready_q) break;
      @(negedge clk);
    end
    items_sent++;
  endtask

  function automatic logic [23:0] pick_delay();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 24'($urandom_range(20));
    if (sel < 85) return 24'($urandom_range(600, 200));
    return 24'($urandom);
  endfunction

  initial begin
    int sel;
    logic [EW-1:0] e;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent    = 0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    rst_n         = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero delay, largest delay, wheel-size boundary, re-schedule,
    // cancel of an unlinked entry, pop on an empty expired list
    send_item(OP_POP,    10'd0,    24'd0);
    send_item(OP_SCHED,  10'd0,    24'd0);
    send_item(OP_SCHED,  10'd1023, 24'hFFFFFF);
    send_item(OP_SCHED,  10'd5,    24'd255);
    send_item(OP_SCHED,  10'd6,    24'd256);
    send_item(OP_SCHED,  10'd7,    24'd1);
    send_item(OP_SCHED,  10'd0,    24'd2);
    send_item(OP_CANCEL, 10'd6,    24'd0);
    send_item(OP_CANCEL, 10'd6,    24'd0);
    send_item(OP_TICK,   10'd0,    24'd0);
    send_item(OP_SCHED,  10'd7,    24'd3);
    send_item(OP_TICK,   10'd0,    24'd0);
    send_item(OP_POP,    10'd0,    24'd0);
    send_item(OP_SCHED,  10'd8,    24'd1);
    send_item(OP_TICK,   10'd0,    24'd0);
    send_item(OP_SCHED,  10'd8,    24'd300);
    send_item(OP_TICK,   10'd0,    24'd0);
    send_item(OP_CANCEL, 10'd7,    24'd0);
    send_item(OP_POP,    10'd0,    24'd0);
    send_item(OP_POP,    10'd0,    24'd0);
    send_item(OP_SCHED,  10'd512,  24'h555555);

    // Random part in three idling phases; tick bursts make the wheel wrap
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        send_idle_pct = 23;
        recv_idle_pct = 46;
      end else if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 23;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      e   = ($urandom_range(99) < 80) ? EW'($urandom_range(47)) : EW'($urandom);
      sel = $urandom_range(99);
      if (sel < 3) begin
        repeat (20) send_item(OP_TICK, EW'($urandom), 24'($urandom));
      end else if (sel < 38) begin
        send_item(OP_SCHED, e, pick_delay());
      end else if (sel < 48) begin
        send_item(OP_CANCEL, e, 24'($urandom));
      end else if (sel < 80) begin
        send_item(OP_TICK, e, 24'($urandom));
      end else begin
        send_item(OP_POP, e, 24'($urandom));
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then a short quiet stretch for stray results
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
